// ===== src/segment_cross_fraction_macros.svh =====
// Assertion macros for the segment_cross_fraction RTL, used by scf_div.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SEGMENT_CROSS_FRACTION_MACROS_SVH
`define SEGMENT_CROSS_FRACTION_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SCF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment_cross_fraction assertion failed");

// Next-cycle implication, checked while out of reset.
`define SCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_cross_fraction assertion failed");

`endif

// ===== src/scf_pkg.sv =====
// Package for segment_cross_fraction: widths, types, register indexes and helpers.
// Used by scf_geom, scf_div and the top level; depends on nothing.
`timescale 1ns / 1ps

package scf_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIX_W      = 32;
    localparam int FRAC       = 16;
    localparam int D_W        = COORD_BITS + 1;
    localparam int P_W        = 2 * D_W;
    localparam int S_W        = P_W + 1;
    localparam int DEN_W      = P_W + 2;
    localparam int R_W        = DEN_W + 1;
    localparam int Q_W        = 32;
    localparam int CFG_W      = 16;
    localparam int ADDR_W     = 4;
    localparam int APB_W      = 32;

    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_END_X   = 2'd2;
    localparam logic [1:0] REG_END_Y   = 2'd3;

    localparam logic [Q_W-1:0] FRAC_MAX  = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] FRAC_MIN  = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [Q_W-1:0] FRAC_NONE = {Q_W{1'b1}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [D_W-1:0]        diff_t;
    typedef logic signed [P_W-1:0]        prod_t;
    typedef logic signed [S_W-1:0]        sum_t;
    typedef logic signed [DEN_W-1:0]      den_t;

    typedef struct packed {
        logic [CFG_W-1:0] start_x;
        logic [CFG_W-1:0] start_y;
        logic [CFG_W-1:0] end_x;
        logic [CFG_W-1:0] end_y;
    } cfg_t;

    typedef struct packed {
        logic crossed;
        sum_t s1;
        den_t den;
    } geom_out_t;

    typedef struct packed {
        logic             crossed;
        logic             dz;
        logic             ovf;
        logic             neg;
        logic [R_W-1:0]   rem;
        logic [DEN_W-1:0] den_mag;
        logic [Q_W-1:0]   numlo;
        logic [Q_W-1:0]   quot;
    } div_stage_t;

    // Integer part of a 16.16 value (floor), held at COORD_BITS bits.
    function automatic coord_t fix_to_coord(input logic [FIX_W-1:0] v);
        logic signed [FIX_W-FRAC-1:0] ip;
        ip = v[FIX_W-1:FRAC];
        return coord_t'(ip);
    endfunction

    // Register value as a coordinate at COORD_BITS bits.
    function automatic coord_t reg_to_coord(input logic [CFG_W-1:0] v);
        logic signed [CFG_W-1:0] sv;
        sv = v;
        return coord_t'(sv);
    endfunction

endpackage

// ===== src/scf_geom.sv =====
// Geometry pipeline: coordinate differences, products, side test and projections.
// Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_geom
    import scf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [FIX_W-1:0] in_a_x,
    input  logic [FIX_W-1:0] in_a_y,
    input  logic [FIX_W-1:0] in_b_x,
    input  logic [FIX_W-1:0] in_b_y,
    output logic             out_valid,
    input  logic             out_ready,
    output geom_out_t        out_data
);

    typedef struct packed {
        diff_t tdx;
        diff_t tdy;
        diff_t dax;
        diff_t day;
        diff_t dbx;
        diff_t dby;
        diff_t eax;
        diff_t eay;
        diff_t nx;
        diff_t ny;
    } diff_stage_t;

    typedef struct packed {
        prod_t pb1;
        prod_t pb2;
        prod_t pa1;
        prod_t pa2;
        prod_t m1;
        prod_t m2;
        prod_t m3;
        prod_t m4;
    } prod_stage_t;

    logic [2:0]  v_reg;
    logic [3:0]  en;
    diff_stage_t d_reg;
    diff_stage_t d_next;
    prod_stage_t p_reg;
    prod_stage_t p_next;
    geom_out_t   g_reg;
    geom_out_t   g_next;

    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    sum_t   s2;

    // A stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        en[3] = out_ready;
        for (int i = 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        ax = fix_to_coord(in_a_x);
        ay = fix_to_coord(in_a_y);
        bx = fix_to_coord(in_b_x);
        by = fix_to_coord(in_b_y);
        sx = reg_to_coord(cfg.start_x);
        sy = reg_to_coord(cfg.start_y);
        ex = reg_to_coord(cfg.end_x);
        ey = reg_to_coord(cfg.end_y);
        d_next.tdx = diff_t'(ex) - diff_t'(sx);
        d_next.tdy = diff_t'(ey) - diff_t'(sy);
        d_next.dax = diff_t'(ax) - diff_t'(sx);
        d_next.day = diff_t'(ay) - diff_t'(sy);
        d_next.dbx = diff_t'(bx) - diff_t'(sx);
        d_next.dby = diff_t'(by) - diff_t'(sy);
        d_next.eax = diff_t'(ex) - diff_t'(ax);
        d_next.eay = diff_t'(ey) - diff_t'(ay);
        d_next.nx  = diff_t'(ay) - diff_t'(by);
        d_next.ny  = diff_t'(bx) - diff_t'(ax);
    end

    always_comb
    begin
        p_next.pb1 = prod_t'(d_reg.tdy) * prod_t'(d_reg.dbx);
        p_next.pb2 = prod_t'(d_reg.dby) * prod_t'(d_reg.tdx);
        p_next.pa1 = prod_t'(d_reg.tdy) * prod_t'(d_reg.dax);
        p_next.pa2 = prod_t'(d_reg.day) * prod_t'(d_reg.tdx);
        p_next.m1  = prod_t'(d_reg.nx) * prod_t'(d_reg.dax);
        p_next.m2  = prod_t'(d_reg.ny) * prod_t'(d_reg.day);
        p_next.m3  = prod_t'(d_reg.nx) * prod_t'(d_reg.eax);
        p_next.m4  = prod_t'(d_reg.ny) * prod_t'(d_reg.eay);
    end

    always_comb
    begin
        g_next.crossed = (p_reg.pa1 < p_reg.pa2) != (p_reg.pb1 < p_reg.pb2);
        g_next.s1      = sum_t'(p_reg.m1) + sum_t'(p_reg.m2);
        s2             = sum_t'(p_reg.m3) + sum_t'(p_reg.m4);
        g_next.den     = den_t'(g_next.s1) + den_t'(s2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) d_reg <= d_next;
        if (en[1]) p_reg <= p_next;
        if (en[2]) g_reg <= g_next;
    end

    assign out_valid = v_reg[2];
    assign out_data  = g_reg;

endmodule

// ===== src/scf_div.sv =====
// Pipelined restoring divider with saturation: one quotient bit per stage.
// Depends on scf_pkg and segment_cross_fraction_macros.svh.
`timescale 1ns / 1ps
`include "segment_cross_fraction_macros.svh"

module scf_div
    import scf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  geom_out_t      in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_crossed,
    output logic [Q_W-1:0] out_fraction
);

    logic [Q_W:0]  v_reg;
    logic [Q_W+1:0] en;
    div_stage_t    st_reg  [0:Q_W];
    div_stage_t    st_next [0:Q_W];
    logic          out_valid_reg;
    logic          crossed_reg;
    logic          crossed_next;
    logic [Q_W-1:0] fraction_reg;
    logic [Q_W-1:0] fraction_next;

    logic [S_W-1:0] s1_mag;
    logic [R_W-1:0] trial;

    always_comb
    begin
        en[Q_W+1] = !out_valid_reg || out_ready;
        for (int i = Q_W; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    // Stage 0 prepares magnitudes, sign and overflow (quotient needs more than Q_W bits);
    // every later stage retires one quotient bit.
    always_comb
    begin
        s1_mag = in_data.s1[S_W-1] ? (~$unsigned(in_data.s1) + 1'b1) : $unsigned(in_data.s1);
        st_next[0].crossed = in_data.crossed;
        st_next[0].dz      = (in_data.den == '0);
        st_next[0].neg     = in_data.s1[S_W-1] ^ in_data.den[DEN_W-1];
        st_next[0].den_mag = in_data.den[DEN_W-1] ? (~$unsigned(in_data.den) + 1'b1)
                                                  : $unsigned(in_data.den);
        st_next[0].ovf     = DEN_W'(s1_mag >> FRAC) >= st_next[0].den_mag;
        st_next[0].rem     = R_W'(s1_mag >> FRAC);
        st_next[0].numlo   = {s1_mag[FRAC-1:0], {(Q_W-FRAC){1'b0}}};
        st_next[0].quot    = '0;

        trial = '0;
        for (int k = 1; k <= Q_W; k++)
        begin
            st_next[k] = st_reg[k-1];
            trial = {st_reg[k-1].rem[R_W-2:0], st_reg[k-1].numlo[Q_W-1]};
            st_next[k].numlo = {st_reg[k-1].numlo[Q_W-2:0], 1'b0};
            if (trial >= R_W'(st_reg[k-1].den_mag))
            begin
                st_next[k].rem  = trial - R_W'(st_reg[k-1].den_mag);
                st_next[k].quot = {st_reg[k-1].quot[Q_W-2:0], 1'b1};
            end
            else
            begin
                st_next[k].rem  = trial;
                st_next[k].quot = {st_reg[k-1].quot[Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        crossed_next = st_reg[Q_W].crossed;
        priority if (!st_reg[Q_W].crossed)
        begin
            fraction_next = FRAC_NONE;
        end
        else if (st_reg[Q_W].dz)
        begin
            fraction_next = FRAC_MAX;
        end
        else if (st_reg[Q_W].ovf)
        begin
            fraction_next = st_reg[Q_W].neg ? FRAC_MIN : FRAC_MAX;
        end
        else if (st_reg[Q_W].neg)
        begin
            fraction_next = (st_reg[Q_W].quot > FRAC_MIN) ? FRAC_MIN
                                                          : (~st_reg[Q_W].quot + 1'b1);
        end
        else
        begin
            fraction_next = st_reg[Q_W].quot[Q_W-1] ? FRAC_MAX : st_reg[Q_W].quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int k = 1; k <= Q_W; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
            if (en[Q_W+1]) out_valid_reg <= v_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= Q_W; k++)
        begin
            if (en[k]) st_reg[k] <= st_next[k];
        end
        if (en[Q_W+1])
        begin
            crossed_reg  <= crossed_next;
            fraction_reg <= fraction_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_crossed  = crossed_reg;
    assign out_fraction = fraction_reg;

    `SCF_ASSERT_IMPL(a_rem_below_den,
        v_reg[Q_W] && st_reg[Q_W].crossed && !st_reg[Q_W].dz && !st_reg[Q_W].ovf,
        st_reg[Q_W].rem < R_W'(st_reg[Q_W].den_mag))
    `SCF_ASSERT_IMPL(a_not_crossed_none,
        out_valid_reg && !crossed_reg, fraction_reg == FRAC_NONE)
    `SCF_ASSERT_NEXT(a_last_stage_moves,
        v_reg[Q_W] && en[Q_W+1], out_valid_reg)

endmodule

// ===== src/segment_cross_fraction.sv =====
// Top level of segment_cross_fraction: APB trace registers, geometry and divider pipelines.
// Depends on scf_pkg, scf_geom and scf_div.
//
//  Channel   Dir  Signals                               Contents
//  s_axis    in   s_tvalid s_tready s_tdata[127:0]      one wall segment, two 16.16 endpoints
//  m_axis    out  m_tvalid m_tready m_tdata[31:0] tuser crossed flag and 16.16 fraction
//  apb       in   psel penable pwrite paddr pwdata ...  trace start and end coordinates
//
// Every word passes 37 register stages: three geometry stages (differences, eight parallel
// 17x17 multipliers, sums and side test), a prepare stage, 32 restoring divider stages that
// retire one quotient bit each, and the saturating output register. A new word may enter
// every cycle unless the stages ahead are full and stalled. Each stage holds its word
// when the next one is full and stalled, so empty stages keep filling while the output
// waits. Reset clears the valid bits and the trace registers to zero.
`timescale 1ns / 1ps

module segment_cross_fraction
    import scf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // s_tdata: seg_a_x [31:0], seg_a_y [63:32], seg_b_x [95:64], seg_b_y [127:96]
    input  logic [4*FIX_W-1:0] s_tdata,
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // m_tdata: fraction [31:0]
    output logic [Q_W-1:0]    m_tdata,
    // m_tuser: crossed [0]
    output logic              m_tuser
);

    logic [CFG_W-1:0] start_x_reg;
    logic [CFG_W-1:0] start_y_reg;
    logic [CFG_W-1:0] end_x_reg;
    logic [CFG_W-1:0] end_y_reg;
    logic             cfg_wr;
    logic [1:0]       reg_idx;
    cfg_t             cfg;

    logic      g_valid;
    logic      g_ready;
    geom_out_t g_data;

    // The port never waits, so a write lands in the access cycle.
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_START_X: start_x_reg <= pwdata[CFG_W-1:0];
                REG_START_Y: start_y_reg <= pwdata[CFG_W-1:0];
                REG_END_X:   end_x_reg   <= pwdata[CFG_W-1:0];
                REG_END_Y:   end_y_reg   <= pwdata[CFG_W-1:0];
                default:     ;
            endcase
        end
    end

    // Reads return the stored 16-bit value, zero-extended.
    always_comb
    begin
        unique case (reg_idx)
            REG_START_X: prdata = APB_W'(start_x_reg);
            REG_START_Y: prdata = APB_W'(start_y_reg);
            REG_END_X:   prdata = APB_W'(end_x_reg);
            REG_END_Y:   prdata = APB_W'(end_y_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.start_x = start_x_reg;
    assign cfg.start_y = start_y_reg;
    assign cfg.end_x   = end_x_reg;
    assign cfg.end_y   = end_y_reg;

    scf_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_a_x    (s_tdata[FIX_W-1:0]),
        .in_a_y    (s_tdata[2*FIX_W-1:FIX_W]),
        .in_b_x    (s_tdata[3*FIX_W-1:2*FIX_W]),
        .in_b_y    (s_tdata[4*FIX_W-1:3*FIX_W]),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .out_data  (g_data)
    );

    scf_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (g_valid),
        .in_ready     (g_ready),
        .in_data      (g_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_crossed  (m_tuser),
        .out_fraction (m_tdata)
    );

endmodule

// ===== bench/testbench.sv =====
// Testbench for segment_cross_fraction: streams wall segments against trace settings
// and checks crossed flag and fraction per word. Depends on scf_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import scf_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [127:0]      s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              m_tuser;

    typedef struct packed {
        logic        crossed;
        logic [31:0] fraction;
    } hit_t;

    // Trace registers as the predictor sees them.
    logic signed [15:0] trace_sx, trace_sy, trace_ex, trace_ey;
    hit_t  hit_queue[$];
    int    error_count = 0;
    int    cycle_count = 0;
    bit    drain_hold;     // long receiver hold-off requested
    bit    quiet_mode;     // no idling on either side
    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 400000;

    segment_cross_fraction u_top (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Cycle watchdog ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Works out the crossing for one segment against the current trace.
    function automatic hit_t crossing_of(input logic [127:0] seg);
        longint ax, ay, bx, by, sx, sy, ex, ey, tdx, tdy;
        longint nx, ny, s1, s2, den, q;
        bit     side_a, side_b;
        hit_t   h;
        ax = longint'($signed(seg[31:16]));
        ay = longint'($signed(seg[63:48]));
        bx = longint'($signed(seg[95:80]));
        by = longint'($signed(seg[127:112]));
        sx = trace_sx; sy = trace_sy; ex = trace_ex; ey = trace_ey;
        tdx = ex - sx;
        tdy = ey - sy;
        side_b = (tdy * (bx - sx)) < ((by - sy) * tdx);
        side_a = (tdy * (ax - sx)) < ((ay - sy) * tdx);
        if (side_a == side_b)
        begin
            h.crossed  = 1'b0;
            h.fraction = FRAC_NONE;
            return h;
        end
        nx = ay - by;
        ny = bx - ax;
        s1 = nx * (ax - sx) + ny * (ay - sy);
        s2 = nx * (ex - ax) + ny * (ey - ay);
        den = s1 + s2;
        if (den == 0)
            q = 64'sd2147483647;
        else
        begin
            // s1 fits in 35 bits, so the shift stays inside 64 bits.
            q = (s1 * 65536) / den;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
        end
        h.crossed  = 1'b1;
        h.fraction = q[31:0];
        return h;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Receiver: random stalls, a long hold-off on request, and the result check.
    initial
    begin
        hit_t want;
        bit   hold_done;
        m_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (hit_queue.size() == 0)
                    report_mismatch("unexpected word", {31'b0, m_tuser}, 32'b0);
                else
                begin
                    want = hit_queue.pop_front();
                    if (m_tuser !== want.crossed)
                        report_mismatch("crossed", {31'b0, m_tuser}, {31'b0, want.crossed});
                    if (m_tdata !== want.fraction)
                        report_mismatch("fraction", m_tdata, want.fraction);
                end
            end
            if (drain_hold && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    // Writes one trace register over APB: setup cycle, then access cycle.
    task automatic write_trace(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= {16'($urandom_range(65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_START_X: trace_sx = value;
            REG_START_Y: trace_sy = value;
            REG_END_X:   trace_ex = value;
            default:     trace_ey = value;
        endcase
    endtask

    task automatic set_trace(input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] ex, input logic [15:0] ey);
        write_trace(REG_START_X, sx);
        write_trace(REG_START_Y, sy);
        write_trace(REG_END_X, ex);
        write_trace(REG_END_Y, ey);
    endtask

    // Sends one segment word and queues its expected crossing.
    task automatic send_segment(input logic [127:0] seg);
        if (!quiet_mode)
            while ($urandom_range(99) < 9)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        hit_queue = {hit_queue, crossing_of(seg)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Waits until every queued result has arrived and the LATENCY margin has passed.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [31:0] fix_pt(input int ip);
        return {ip[15:0], 16'($urandom)};
    endfunction

    function automatic logic [127:0] seg_of(input int ax, input int ay,
                                            input int bx, input int by);
        return {fix_pt(by), fix_pt(bx), fix_pt(ay), fix_pt(ax)};
    endfunction

    task automatic test_directed();
        set_trace(16'd0, 16'd0, 16'd100, 16'd0);
        send_segment(seg_of(50, -10, 50, 10));      // plain crossing
        send_segment(seg_of(50, 10, 50, -10));      // reversed endpoints
        send_segment(seg_of(10, 5, 90, 5));         // parallel, same side
        send_segment(seg_of(40, 0, 40, 20));        // endpoint on the line
        send_segment(seg_of(40, -20, 40, 0));
        send_segment(seg_of(-50, -1, -50, 1));      // before trace start
        send_segment(seg_of(500, -1, 500, 1));      // far beyond the trace end
        send_segment({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000});
        send_segment({32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000});
        send_segment({128{1'b1}});
        send_segment(128'b0);
        wait_drained();
        // Zero-length trace: divisor can vanish.
        set_trace(16'd7, 16'd7, 16'd7, 16'd7);
        send_segment(seg_of(0, 0, 10, 10));
        send_segment(seg_of(0, 10, 10, 0));
        wait_drained();
        // Extreme corners.
        set_trace(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_segment(seg_of(-32768, 32767, 32767, -32768));
        send_segment(seg_of(32767, -32768, -32768, 32767));
        send_segment(seg_of(-32768, -32767, 32767, 32766));
        send_segment({32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000});
        send_segment(seg_of(0, 1, 1, 0));
        wait_drained();
        set_trace(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_segment(seg_of(0, 0, 1, 1));
        send_segment(seg_of(-32768, -32768, 32767, 32767));
        wait_drained();
    endtask

    // Random segments centred near the trace start, with an occasional fully random word.
    task automatic test_random(input int count, input int spread);
        int cx, cy;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_segment({$urandom, $urandom, $urandom, $urandom});
            else
            begin
                cx = int'(trace_sx) + $urandom_range(2 * spread) - spread;
                cy = int'(trace_sy) + $urandom_range(2 * spread) - spread;
                send_segment(seg_of(cx + $urandom_range(2 * spread) - spread,
                                    cy + $urandom_range(2 * spread) - spread,
                                    cx - $urandom_range(2 * spread) + spread,
                                    cy - $urandom_range(2 * spread) + spread));
            end
        end
    endtask

    task automatic test_settings();
        for (int p = 0; p < 6; p++)
        begin
            set_trace(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            quiet_mode = (p == 2);
            test_random(80, (p % 2) ? 30000 : 200);
            wait_drained();
        end
        quiet_mode = 1'b0;
    endtask

    // Receiver holds off while the sender keeps pushing words into the pipe.
    task automatic test_backpressure();
        set_trace(16'hFF00, 16'h0040, 16'h0100, 16'hFFC0);
        drain_hold = 1'b1;
        test_random(90, 400);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        trace_sx = 0; trace_sy = 0; trace_ex = 0; trace_ey = 0;
        drain_hold = 1'b0;
        quiet_mode = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_settings();
        test_backpressure();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
